// File: hdl/button_sequence_lock_unit_assert.svh
// ----------------------------------------------------------------------------
// Button sequence lock assertion macros
// Concurrent assertion wrappers clocked on aclk; they compile to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef BUTTON_SEQUENCE_LOCK_UNIT_ASSERT_SVH
`define BUTTON_SEQUENCE_LOCK_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset.
`define BSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define BSL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define BSL_ASSERT(label, prop, msg)
`define BSL_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: hdl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// Button sequence lock package
// Fixed sizes, register indexes and reset values shared by the lock unit.
// ----------------------------------------------------------------------------
package bsl_pkg;

    // Pattern and button geometry.
    localparam int unsigned PATTERN_LEN  = 5;
    localparam int unsigned BUTTON_COUNT = 4;
    localparam int unsigned PROG_W       = 3;
    localparam int unsigned BTN_W        = 2;
    localparam int unsigned PATTERN_W    = PATTERN_LEN * BTN_W;
    localparam int unsigned EDGES_W      = 4;
    localparam int unsigned TIME_W       = 32;

    // Stream payload widths, padded to whole bytes.
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 8;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_CODE  = 8'd0,
        CFG_INPUT_TIMEOUT = 8'd1,
        CFG_UNLOCK_HOLD   = 8'd2,
        CFG_ERROR_FLASH   = 8'd3
    } cfg_index_t;

    // Register reset values.
    localparam logic [PATTERN_W-1:0] PATTERN_CODE_RST  = '0;
    localparam logic [TIME_W-1:0]    INPUT_TIMEOUT_RST = 32'd2500;
    localparam logic [TIME_W-1:0]    UNLOCK_HOLD_RST   = 32'd8000;
    localparam logic [TIME_W-1:0]    ERROR_FLASH_RST   = 32'd500;

endpackage

// File: hdl/button_sequence_lock_unit.sv
// ----------------------------------------------------------------------------
// Button sequence lock unit
// Combination lock opened by a secret sequence of button presses, with an
// inter-press timeout, an unlock hold time and an error-flash window.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless m_tready holds the result register; the state
// update between the input register and the result register is combinational.
// Reset: aresetn is synchronous, active low; it empties both registers,
// clears the lock state and loads the configuration reset values.
module button_sequence_lock_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream. s_tdata, from bit 0: now_time[31:0], press_edges[3:0], zeros.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bsl_pkg::S_DATA_W-1:0]  s_tdata,
    // Result stream. m_tdata, from bit 0: is_unlocked, progress_count[2:0],
    // error_flash, unlock_event, wrong_press, zero.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bsl_pkg::M_DATA_W-1:0]  m_tdata,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bsl_pkg::*;

    `include "button_sequence_lock_unit_assert.svh"

    // Configuration registers.
    logic [PATTERN_W-1:0] pattern_code_reg;
    logic [TIME_W-1:0]    input_timeout_reg;
    logic [TIME_W-1:0]    unlock_hold_reg;
    logic [TIME_W-1:0]    error_flash_ticks_reg;

    // Lock state.
    logic [PROG_W-1:0] progress_reg, progress_next;
    logic              open_reg, open_next;
    logic [TIME_W-1:0] last_press_reg, last_press_next;
    logic [TIME_W-1:0] open_since_reg, open_since_next;
    logic [TIME_W-1:0] error_end_reg, error_end_next;

    // Input register.
    logic               in_valid_reg;
    logic [TIME_W-1:0]  in_now_reg;
    logic [EDGES_W-1:0] in_edges_reg;

    // Result register.
    logic              out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    // Handshake: the input item moves on when the result slot is free.
    logic advance;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes outside the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_code_reg      <= PATTERN_CODE_RST;
            input_timeout_reg     <= INPUT_TIMEOUT_RST;
            unlock_hold_reg       <= UNLOCK_HOLD_RST;
            error_flash_ticks_reg <= ERROR_FLASH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PATTERN_CODE:  pattern_code_reg      <= cfg_data[PATTERN_W-1:0];
                CFG_INPUT_TIMEOUT: input_timeout_reg     <= cfg_data[TIME_W-1:0];
                CFG_UNLOCK_HOLD:   unlock_hold_reg       <= cfg_data[TIME_W-1:0];
                CFG_ERROR_FLASH:   error_flash_ticks_reg <= cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Lowest-index pressed button.
    logic             press_any;
    logic [BTN_W-1:0] btn_idx;
    always_comb begin
        press_any = 1'b0;
        btn_idx   = '0;
        for (int b = BUTTON_COUNT - 1; b >= 0; b--) begin
            if (in_edges_reg[b]) begin
                press_any = 1'b1;
                btn_idx   = BTN_W'(b);
            end
        end
    end

    // Pattern widened so that any 3-bit progress selects a defined entry.
    logic [2*(1 << PROG_W)-1:0] pattern_ext;
    assign pattern_ext = (2*(1 << PROG_W))'(pattern_code_reg);

    // Next lock state for the item in the input register.
    logic [TIME_W-1:0] open_age, press_gap;
    logic [PROG_W-1:0] prog_timed, prog_cur, prog_inc;
    logic [BTN_W-1:0]  entry_cur;
    logic              unlock_ev, wrong_ev, flash_on;
    always_comb begin
        open_age        = in_now_reg - open_since_reg;
        press_gap       = in_now_reg - last_press_reg;
        progress_next   = progress_reg;
        open_next       = open_reg;
        last_press_next = last_press_reg;
        open_since_next = open_since_reg;
        error_end_next  = error_end_reg;
        unlock_ev       = 1'b0;
        wrong_ev        = 1'b0;
        prog_timed      = progress_reg;
        prog_cur        = progress_reg;
        prog_inc        = progress_reg;
        entry_cur       = '0;

        if (open_reg) begin
            // Unlocked: only the hold time matters, presses are ignored.
            if (open_age >= unlock_hold_reg) begin
                open_next = 1'b0;
            end
        end else begin
            // A long gap since the last press clears partial progress.
            if (progress_reg != '0 && press_gap >= input_timeout_reg) begin
                prog_timed = '0;
            end
            progress_next = prog_timed;
            prog_cur  = (prog_timed >= PROG_W'(PATTERN_LEN)) ? '0 : prog_timed;
            entry_cur = pattern_ext[{prog_cur, 1'b0} +: BTN_W];
            prog_inc  = prog_cur + PROG_W'(1);
            if (press_any) begin
                last_press_next = in_now_reg;
                if (btn_idx == entry_cur) begin
                    if (prog_inc == PROG_W'(PATTERN_LEN)) begin
                        // Pattern complete: open the lock.
                        open_next       = 1'b1;
                        open_since_next = in_now_reg;
                        progress_next   = '0;
                        error_end_next  = '0;
                        unlock_ev       = 1'b1;
                    end else begin
                        progress_next = prog_inc;
                    end
                end else begin
                    // Wrong button: restart, counting it if it opens the pattern.
                    progress_next  = (btn_idx == pattern_ext[BTN_W-1:0]) ?
                                     PROG_W'(1) : '0;
                    error_end_next = in_now_reg + error_flash_ticks_reg;
                    wrong_ev       = 1'b1;
                end
            end
        end

        flash_on      = !open_next && (in_now_reg < error_end_next);
        out_data_next = {1'b0, wrong_ev, unlock_ev, flash_on, progress_next, open_next};
    end

    // Input register and valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_now_reg   <= s_tdata[TIME_W-1:0];
            in_edges_reg <= s_tdata[TIME_W +: EDGES_W];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Lock state commits when an item moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            progress_reg   <= '0;
            open_reg       <= 1'b0;
            last_press_reg <= '0;
            open_since_reg <= '0;
            error_end_reg  <= '0;
        end else if (advance) begin
            progress_reg   <= progress_next;
            open_reg       <= open_next;
            last_press_reg <= last_press_next;
            open_since_reg <= open_since_next;
            error_end_reg  <= error_end_next;
        end
    end

    // Checks on the lock state and the result register.
    `BSL_ASSERT(a_progress_range, progress_reg < PROG_W'(PATTERN_LEN), "progress out of range")
    `BSL_ASSERT(a_open_no_progress, open_reg |-> progress_reg == '0, "progress kept while open")
    `BSL_ASSERT(a_unlock_result, m_tvalid && m_tdata[5] |-> m_tdata[6:0] == 7'h21, "bad unlock")
    `BSL_ASSERT(a_stall_cause, !s_tready |-> in_valid_reg && out_valid_reg && !m_tready, "bad stall")
    `BSL_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid && s_tready, "not empty after reset")

endmodule

// File: tb/bsl_lock_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button sequence lock checker
// Watches the input, result and configuration channels of the lock unit. It
// keeps its own copy of the lock state, predicts one status item for every
// accepted input item and compares each accepted result with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module bsl_lock_checker
    import bsl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // s_tdata, from bit 0: now_time[31:0], press_edges[3:0], zeros.
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, from bit 0: is_unlocked, progress_count[2:0], error_flash,
    // unlock_event, wrong_press, zero.
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding
);

    typedef struct {
        logic              unlocked;
        logic [PROG_W-1:0] prog;
        logic              flash;
        logic              opened;
        logic              wrong;
    } lock_status_t;

    // Shadow of the configuration registers.
    logic [PATTERN_W-1:0] pattern_r;
    logic [TIME_W-1:0]    timeout_r;
    logic [TIME_W-1:0]    hold_r;
    logic [TIME_W-1:0]    flash_len_r;

    // Shadow of the lock state.
    logic [PROG_W-1:0]    prog_r;
    logic                 open_r;
    logic [TIME_W-1:0]    last_press_r;
    logic [TIME_W-1:0]    open_since_r;
    logic [TIME_W-1:0]    err_end_r;

    lock_status_t expected_status_q[$];
    int mismatches = 0;

    // Advances the lock by one tick and returns the status it reports.
    function automatic lock_status_t step_lock(input logic [TIME_W-1:0] now,
                                               input logic [EDGES_W-1:0] edges);
        lock_status_t st;
        int btn;
        int i;
        logic [BTN_W-1:0] b;
        st.opened = 1'b0;
        st.wrong  = 1'b0;
        if (open_r) begin
            // While open, only the hold time matters; presses are dropped.
            if (now - open_since_r >= hold_r)
                open_r = 1'b0;
        end else begin
            if (prog_r != 0 && now - last_press_r >= timeout_r)
                prog_r = '0;
            // The lowest pressed button wins.
            btn = -1;
            for (i = BUTTON_COUNT - 1; i >= 0; i--) begin
                if (edges[i])
                    btn = i;
            end
            if (btn >= 0) begin
                b = btn[BTN_W-1:0];
                last_press_r = now;
                if (prog_r >= PATTERN_LEN)
                    prog_r = '0;
                if (b == pattern_r[2*prog_r +: BTN_W]) begin
                    prog_r = prog_r + 1'b1;
                    if (prog_r == PATTERN_LEN) begin
                        open_r       = 1'b1;
                        open_since_r = now;
                        prog_r       = '0;
                        err_end_r    = '0;
                        st.opened    = 1'b1;
                    end
                end else begin
                    // A wrong press may itself be the start of a new attempt.
                    prog_r    = (b == pattern_r[BTN_W-1:0]) ? 3'd1 : 3'd0;
                    err_end_r = now + flash_len_r;
                    st.wrong  = 1'b1;
                end
            end
        end
        st.unlocked = open_r;
        st.prog     = prog_r;
        st.flash    = !open_r && (now < err_end_r);
        return st;
    endfunction

    // Channel monitor: results are compared before the new item is predicted.
    always @(posedge aclk) begin
        lock_status_t got;
        lock_status_t want;
        logic bad;
        if (!aresetn) begin
            pattern_r    = PATTERN_CODE_RST;
            timeout_r    = INPUT_TIMEOUT_RST;
            hold_r       = UNLOCK_HOLD_RST;
            flash_len_r  = ERROR_FLASH_RST;
            prog_r       = '0;
            open_r       = 1'b0;
            last_press_r = '0;
            open_since_r = '0;
            err_end_r    = '0;
            expected_status_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.unlocked = m_tdata[0];
                got.prog     = m_tdata[3:1];
                got.flash    = m_tdata[4];
                got.opened   = m_tdata[5];
                got.wrong    = m_tdata[6];
                if (expected_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item 0x%02h arrived with nothing pending",
                                 $time, m_tdata);
                end else begin
                    want = expected_status_q.pop_front();
                    bad = (got.unlocked !== want.unlocked) || (got.prog !== want.prog) ||
                          (got.flash !== want.flash) || (got.opened !== want.opened) ||
                          (got.wrong !== want.wrong);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch, expected unlocked=%0b progress=%0d ",
                                      "flash=%0b unlock_event=%0b wrong_press=%0b, got ",
                                      "unlocked=%0b progress=%0d flash=%0b ",
                                      "unlock_event=%0b wrong_press=%0b"},
                                     $time, want.unlocked, want.prog, want.flash,
                                     want.opened, want.wrong, got.unlocked, got.prog,
                                     got.flash, got.opened, got.wrong);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PATTERN_CODE:  pattern_r   = cfg_data[PATTERN_W-1:0];
                    CFG_INPUT_TIMEOUT: timeout_r   = cfg_data;
                    CFG_UNLOCK_HOLD:   hold_r      = cfg_data;
                    CFG_ERROR_FLASH:   flash_len_r = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_status_q.push_back(step_lock(s_tdata[TIME_W-1:0],
                                                      s_tdata[TIME_W +: EDGES_W]));
        end
        fail_count  <= mismatches;
        outstanding <= expected_status_q.size();
    end

endmodule

// File: tb/tb_button_sequence_lock_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button sequence lock unit testbench
// Drives timer ticks with button presses into the lock unit: a directed run
// through unlocking, hold expiry, wrong presses, timeouts and timestamp wrap,
// then random pattern attempts and noise under several register settings,
// extremes included. Both stream sides idle at random. A separate checker
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_button_sequence_lock_unit;
    import bsl_pkg::*;

    localparam int IDLE_LIMIT = 1000;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } rx_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    outstanding;

    // Register values as last written, used to shape the stimulus.
    logic [PATTERN_W-1:0]  pattern_cfg = PATTERN_CODE_RST;
    logic [TIME_W-1:0]     timeout_cfg = INPUT_TIMEOUT_RST;
    logic [TIME_W-1:0]     hold_cfg    = UNLOCK_HOLD_RST;
    logic [TIME_W-1:0]     flash_cfg   = ERROR_FLASH_RST;

    logic [TIME_W-1:0]     tick_time   = '0;
    int                    burst_left  = 0;
    int                    items_sent  = 0;
    int                    idle_cycles = 0;
    int                    rx_cycle    = 0;
    rx_mode_t              rx_mode     = RX_ALWAYS;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    button_sequence_lock_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bsl_lock_checker checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // The result side periodically switches to a randomly chosen stall pattern.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
        case (rx_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            default:     m_tready <= (rx_cycle % 11) >= 4;
        endcase
    end

    // Watchdog: ends the run when no channel moves an item for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one item; the sender works in bursts with random gaps between them.
    task automatic send_item(input logic [TIME_W-1:0] stamp,
                             input logic [EDGES_W-1:0] edges);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tdata  <= {{(S_DATA_W - TIME_W - EDGES_W){1'b0}}, edges, stamp};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    // Advances the timestamp and sends the tick.
    task automatic tick(input logic [TIME_W-1:0] delta, input logic [EDGES_W-1:0] edges);
        tick_time = tick_time + delta;
        send_item(tick_time, edges);
    endtask

    // Lets the block drain before registers are touched again.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Writes all four registers; junk above the pattern bits must be dropped.
    task automatic write_config(input logic [PATTERN_W-1:0] pat,
                                input logic [TIME_W-1:0] tmo,
                                input logic [TIME_W-1:0] hold,
                                input logic [TIME_W-1:0] flash);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        put_reg(CFG_PATTERN_CODE, {junk[CFG_DATA_W-1:PATTERN_W], pat});
        put_reg(CFG_INPUT_TIMEOUT, tmo);
        put_reg(CFG_UNLOCK_HOLD, hold);
        put_reg(CFG_ERROR_FLASH, flash);
        cfg_valid   <= 1'b0;
        pattern_cfg = pat;
        timeout_cfg = tmo;
        hold_cfg    = hold;
        flash_cfg   = flash;
    endtask

    // Press vector whose lowest set bit is the given button.
    function automatic logic [EDGES_W-1:0] press_of(input logic [BTN_W-1:0] b);
        logic [EDGES_W-1:0] one_hot;
        logic [EDGES_W-1:0] extra;
        one_hot = 4'b0001 << b;
        extra   = ($urandom_range(0, 1) == 0) ? '0 : EDGES_W'($urandom_range(0, 15));
        return (extra | one_hot) & ~(one_hot - 1'b1);
    endfunction

    // Tick spacing; attempts mostly keep presses close, now and then near the timeout;
    // otherwise gaps are short, sit near the timer thresholds or fall anywhere in the 32-bit range.
    function automatic logic [TIME_W-1:0] pick_gap(input logic in_attempt);
        int r;
        r = $urandom_range(0, 99);
        if (in_attempt) begin
            if (r < 85)
                return $urandom_range(1, 8);
            return timeout_cfg + $urandom_range(0, 4) - 2;
        end
        if (r < 40)
            return $urandom_range(0, 20);
        if (r < 60)
            return hold_cfg + $urandom_range(0, 4) - 2;
        if (r < 75)
            return timeout_cfg + $urandom_range(0, 4) - 2;
        if (r < 85)
            return flash_cfg + $urandom_range(0, 4) - 2;
        if (r < 95)
            return $urandom;
        return '0;
    endfunction

    // One attempt at the secret pattern, sometimes with a slip or a pause.
    task automatic try_pattern();
        int k;
        logic [BTN_W-1:0] b;
        if ($urandom_range(0, 1) == 0)
            tick(hold_cfg + $urandom_range(0, 2), press_of(BTN_W'($urandom_range(0, 3))));
        for (k = 0; k < PATTERN_LEN; k++) begin
            if ($urandom_range(0, 5) == 0)
                tick(pick_gap(1'b1), '0);
            b = pattern_cfg[2*k +: BTN_W];
            if ($urandom_range(0, 15) == 0)
                b = BTN_W'($urandom_range(0, 3));
            tick(pick_gap(1'b1), press_of(b));
        end
    endtask

    // Random traffic: mostly pattern attempts, the rest idle ticks and noise.
    task automatic run_phase(input int count);
        int stop_at;
        int r;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                try_pattern();
            else if (r < 70)
                tick(pick_gap(1'b0), '0);
            else
                tick(pick_gap(1'b0), EDGES_W'($urandom_range(0, 15)));
        end
        settle();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset pattern: five presses of button 0 open the lock.
        tick(0, 4'b0000);
        tick(1, 4'b0001);
        tick(1, 4'b1111);
        tick(1, 4'b0001);
        tick(1, 4'b0001);
        tick(1, 4'b0001);
        // Presses are ignored while open, also on the tick the hold runs out.
        tick(10, 4'b0010);
        tick(7989, 4'b0000);
        tick(1, 4'b0001);
        // Wrong presses start the error flash.
        tick(1, 4'b0010);
        tick(1, 4'b0000);
        tick(1, 4'b0100);
        // A long gap clears partial progress.
        tick(1, 4'b0001);
        tick(2500, 4'b0001);
        settle();

        // Pattern 1,2,3,0,1: a slip onto the first entry restarts at one.
        write_config(10'h139, INPUT_TIMEOUT_RST, UNLOCK_HOLD_RST, ERROR_FLASH_RST);
        tick(1, 4'b0010);
        tick(1, 4'b0010);
        tick(1, 4'b0100);
        tick(1, 4'b1000);
        tick(1, 4'b0000);
        tick(1, 4'b0001);
        tick(1, 4'b0010);
        // Timestamp wrap: the hold expires, then the error window end wraps.
        tick(32'hFFFF_FFF0 - tick_time, 4'b0010);
        tick(1, 4'b1000);
        tick(20, 4'b0000);
        settle();

        write_config(PATTERN_W'($urandom_range(0, 1023)), 300, 400, 100);
        run_phase(400);
        write_config(10'h3FF, '0, '0, '0);
        run_phase(150);
        write_config(PATTERN_W'($urandom_range(0, 1023)), '1, '1, '1);
        run_phase(100);
        write_config(PATTERN_W'($urandom_range(0, 1023)), INPUT_TIMEOUT_RST,
                     UNLOCK_HOLD_RST, ERROR_FLASH_RST);
        run_phase(400);
        write_config(PATTERN_W'($urandom_range(0, 1023)), 64, 128, 1000);
        tick(32'hFFFF_F000 - tick_time, '0);
        run_phase(300);
        repeat (3) begin
            write_config(PATTERN_W'($urandom_range(0, 1023)), $urandom_range(1, 200),
                         $urandom_range(1, 300), $urandom_range(0, 300));
            run_phase(150);
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
